// File: hdl/cldcq_pkg.sv
// Shared types and operation codes for the chained LED driver command queue.
package cldcq_pkg;

	// Operation codes carried in the input beat.
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_COLUMN  = 2'd1;
	localparam logic [1:0] OP_EXECUTE = 2'd2;

	// Register byte sent by a segment whose queue is empty.
	localparam logic [7:0] NOOP_REG = 8'd0;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FRAME  = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] segment;
		logic [7:0] reg_addr;
		logic [7:0] payload;
		logic [4:0] column;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] frame_byte;
		logic       last;
		logic       pending;
		logic       dropped;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic shadow_rd;
		logic commit;
		logic pop;
		logic load_status;
		logic load_hi;
		logic load_lo;
		logic seg_dec;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic seg_zero;
	} dp_status_t;

endpackage

// File: hdl/cldcq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cldcq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/cldcq_dp.sv
// Datapath: queue pointers, command and shadow memories, and the output register.
module cldcq_dp #(
	parameter int SEGMENTS    = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cldcq_pkg::in_item_t  in_item,
	input  cldcq_pkg::dp_cmd_t   cmd,
	output cldcq_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cldcq_pkg::out_item_t out_item
);

	localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int NCOLS = SEGMENTS * 8;
	localparam int COL_W = $clog2(NCOLS);
	localparam int QADDR_W = SEG_W + PTR_W;

	// Captured item.
	logic [1:0]       op_q;
	logic [SEG_W-1:0] seg_q;
	logic             seg_ok_q;
	logic [7:0]       reg_q;
	logic [7:0]       data_q;
	logic [COL_W-1:0] col_q;
	logic             col_in_q;
	logic             drop_q;
	logic             pend_after_q;
	logic             nonempty_q;
	logic             shv_q;

	// Per segment pointers and shadow valid bits.
	logic [PTR_W-1:0] wp_q [SEGMENTS];
	logic [PTR_W-1:0] rp_q [SEGMENTS];
	logic [NCOLS-1:0] sv_q;

	// Output register.
	logic                 out_valid_q;
	cldcq_pkg::out_item_t out_q;

	logic [2:0]       seg_ext;
	logic [2:0]       colseg_ext;
	logic [5:0]       col_ext;
	logic [PTR_W-1:0] cur_wp;
	logic [PTR_W-1:0] cur_rp;
	logic [PTR_W-1:0] next_wp;
	logic [PTR_W-1:0] next_rp;
	logic             full;
	logic             push_ok;
	logic [7:0]       shadow_val;
	logic             col_change;
	logic             want;
	logic             any_now;
	logic             any_after;
	logic [15:0]      q_rd;
	logic [7:0]       sh_rd;
	logic             q_wr;
	logic             sh_wr;

	assign seg_ext    = {1'b0, in_item.segment};
	assign colseg_ext = {1'b0, in_item.column[4:3]};
	assign col_ext    = {1'b0, in_item.column};

	// Pointers of the segment in hand.
	assign cur_wp  = wp_q[seg_q];
	assign cur_rp  = rp_q[seg_q];
	assign next_wp = (cur_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
	assign next_rp = (cur_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
	assign full    = (next_wp == cur_rp);
	assign push_ok = seg_ok_q && !full;

	// A never written shadow entry reads as zero.
	assign shadow_val = shv_q ? sh_rd : 8'd0;
	assign col_change = col_in_q && (shadow_val != data_q);
	assign want       = (op_q == cldcq_pkg::OP_PUSH) || col_change;
	assign q_wr       = cmd.commit && want && push_ok;
	assign sh_wr      = q_wr && (op_q == cldcq_pkg::OP_COLUMN);

	// Occupancy now, and after every nonempty queue gives up one entry.
	always_comb begin
		any_now   = 1'b0;
		any_after = 1'b0;
		for (int s = 0; s < SEGMENTS; s++) begin
			if (rp_q[s] != wp_q[s]) begin
				any_now = 1'b1;
				if (((rp_q[s] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q[s] + 1'b1) != wp_q[s]) begin
					any_after = 1'b1;
				end
			end
		end
	end

	// Item capture and per step registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= in_item.operation;
			data_q       <= in_item.payload;
			col_q        <= col_ext[COL_W-1:0];
			col_in_q     <= (7'(in_item.column) < 7'(NCOLS));
			// A column write takes its segment from the column, which is range checked apart.
			seg_ok_q     <= (in_item.operation == cldcq_pkg::OP_COLUMN) ||
				(4'(in_item.segment) < 4'(SEGMENTS));
			pend_after_q <= any_after;
			if (in_item.operation == cldcq_pkg::OP_COLUMN) begin
				seg_q <= colseg_ext[SEG_W-1:0];
				reg_q <= 8'(in_item.column[2:0]) + 8'd1;
			end else if (in_item.operation == cldcq_pkg::OP_EXECUTE) begin
				seg_q <= SEG_W'(SEGMENTS - 1);
				reg_q <= in_item.reg_addr;
			end else begin
				seg_q <= seg_ext[SEG_W-1:0];
				reg_q <= in_item.reg_addr;
			end
		end else if (cmd.seg_dec) begin
			seg_q <= seg_q - 1'b1;
		end
		if (cmd.shadow_rd) begin
			shv_q <= sv_q[col_q];
		end
		if (cmd.pop) begin
			nonempty_q <= (cur_rp != cur_wp);
		end
	end

	// Drop flag for the status beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cmd.capture) begin
			drop_q <= 1'b0;
		end else if (cmd.commit && want && !push_ok) begin
			drop_q <= 1'b1;
		end
	end

	// Queue pointers and shadow valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SEGMENTS; s++) begin
				wp_q[s] <= '0;
				rp_q[s] <= '0;
			end
			sv_q <= '0;
		end else begin
			if (q_wr) begin
				wp_q[seg_q] <= next_wp;
			end
			if (cmd.pop && (cur_rp != cur_wp)) begin
				rp_q[seg_q] <= next_rp;
			end
			if (sh_wr) begin
				sv_q[col_q] <= 1'b1;
			end
		end
	end

	// Command store, one slice of entries per segment.
	cldcq_ram #(
		.WIDTH(16),
		.DEPTH(2 ** QADDR_W)
	) u_queue_ram (
		.clk    (clk),
		.wr_en  (q_wr),
		.wr_addr({seg_q, cur_wp}),
		.wr_data({reg_q, data_q}),
		.rd_en  (cmd.pop),
		.rd_addr({seg_q, cur_rp}),
		.rd_data(q_rd)
	);

	// Shadow of the columns already sent.
	cldcq_ram #(
		.WIDTH(8),
		.DEPTH(2 ** COL_W)
	) u_shadow_ram (
		.clk    (clk),
		.wr_en  (sh_wr),
		.wr_addr(col_q),
		.wr_data(data_q),
		.rd_en  (cmd.shadow_rd),
		.rd_addr(col_q),
		.rd_data(sh_rd)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_status || cmd.load_hi || cmd.load_lo) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_q.kind       <= cldcq_pkg::KIND_STATUS;
			out_q.frame_byte <= 8'd0;
			out_q.last       <= 1'b1;
			out_q.pending    <= any_now;
			out_q.dropped    <= drop_q;
		end else if (cmd.load_hi || cmd.load_lo) begin
			out_q.kind    <= cldcq_pkg::KIND_FRAME;
			out_q.pending <= pend_after_q;
			out_q.dropped <= 1'b0;
			out_q.last    <= cmd.load_lo && (seg_q == '0);
			if (!nonempty_q) begin
				out_q.frame_byte <= cmd.load_hi ? cldcq_pkg::NOOP_REG : 8'd0;
			end else begin
				out_q.frame_byte <= cmd.load_hi ? q_rd[15:8] : q_rd[7:0];
			end
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.seg_zero = (seg_q == '0);
	assign out_valid       = out_valid_q;
	assign out_item        = out_q;

endmodule

// File: hdl/cldcq_ctrl.sv
// Controller state machine that sequences pushes, column writes and frames.
module cldcq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_op,
	output logic                  in_ready,
	input  cldcq_pkg::dp_status_t status,
	output cldcq_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ENQ  = 3'd1;
	localparam logic [2:0] ST_CRD  = 3'd2;
	localparam logic [2:0] ST_CCMP = 3'd3;
	localparam logic [2:0] ST_STAT = 3'd4;
	localparam logic [2:0] ST_POP  = 3'd5;
	localparam logic [2:0] ST_HI   = 3'd6;
	localparam logic [2:0] ST_LO   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_op)
						cldcq_pkg::OP_PUSH:    state_d = ST_ENQ;
						cldcq_pkg::OP_COLUMN:  state_d = ST_CRD;
						cldcq_pkg::OP_EXECUTE: state_d = ST_POP;
						default:               state_d = ST_STAT;
					endcase
				end
			end
			ST_ENQ: begin
				cmd.commit = 1'b1;
				state_d    = ST_STAT;
			end
			ST_CRD: begin
				cmd.shadow_rd = 1'b1;
				state_d       = ST_CCMP;
			end
			ST_CCMP: begin
				cmd.commit = 1'b1;
				state_d    = ST_STAT;
			end
			ST_STAT: begin
				if (status.out_free) begin
					cmd.load_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_HI;
			end
			ST_HI: begin
				if (status.out_free) begin
					cmd.load_hi = 1'b1;
					state_d     = ST_LO;
				end
			end
			ST_LO: begin
				if (status.out_free) begin
					cmd.load_lo = 1'b1;
					if (status.seg_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.seg_dec = 1'b1;
						state_d     = ST_POP;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/chained_led_driver_command_queue_top.sv
// Top level of the chained LED driver command queue.
//
// One item is taken at a time. A push passes through the queue update and the
// loading of its status beat, and a column write adds the registered read of
// the shadow memory ahead of the queue update. An execute emits 2*SEGMENTS
// frame bytes, highest segment first: for each segment the block reads the
// segment's next command from the shared command memory, then loads each byte
// in turn through the output register. A stalled sink holds the block until
// the output register is free again. The output register lets the next item be
// accepted while the last beat still waits. A full queue or a segment out of
// range drops the push and raises dropped on the status beat.
// Shadow columns read as zero until written; no clearing pass is needed after
// reset.
module chained_led_driver_command_queue_top #(
	parameter int SEGMENTS    = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cldcq_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cldcq_pkg::out_item_t out_item
);

	cldcq_pkg::dp_cmd_t    cmd;
	cldcq_pkg::dp_status_t status;

	// Sequencing.
	cldcq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (in_item.operation),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// Queues, shadow and output beat.
	cldcq_dp #(
		.SEGMENTS   (SEGMENTS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.status   (status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// A status beat is always last and carries no frame byte.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.kind == cldcq_pkg::KIND_STATUS)
		|-> out_item.last && (out_item.frame_byte == 8'd0))
		else $error("status beat without last or with a frame byte");

	// Frame bytes never report a dropped push.
	a_frame_nodrop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.kind == cldcq_pkg::KIND_FRAME) |-> !out_item.dropped)
		else $error("frame beat flagged as dropped");

	// One item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

endmodule

// File: bench/chained_led_driver_command_queue_top_tb.sv
// Self-checking testbench for the chained LED driver command queue top level.
`timescale 1ns / 1ps

module chained_led_driver_command_queue_top_tb;

	localparam int SEGS        = 4;
	localparam int DEPTH       = 16;
	localparam int NCOLS       = SEGS * 8;
	localparam int FRAME_BYTES = 2 * SEGS;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 3 * SEGS + 8;

	// The operation code the block leaves unused.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	cldcq_pkg::in_item_t  in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	cldcq_pkg::out_item_t out_item;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int stall_cycles   = 0;

	// Predicted state: per-segment command rings and the column shadow.
	logic [15:0]          cmd_store [SEGS * DEPTH];
	logic [3:0]           wr_idx [SEGS];
	logic [3:0]           rd_idx [SEGS];
	logic [7:0]           shadow_cols [NCOLS];
	cldcq_pkg::out_item_t expected_beats [$];

	chained_led_driver_command_queue_top #(
		.SEGMENTS   (SEGS),
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// True while any segment still holds a command.
	function automatic bit commands_waiting();
		for (int s = 0; s < SEGS; s++) begin
			if (wr_idx[s] != rd_idx[s]) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Stores one command; a full ring or a bad segment refuses it.
	function automatic bit enqueue_command(int seg, logic [7:0] reg_byte, logic [7:0] data_byte);
		logic [3:0] next_idx;
		if (seg >= SEGS) return 1'b0;
		next_idx = 4'((wr_idx[seg] + 1) % DEPTH);
		if (next_idx == rd_idx[seg]) return 1'b0;
		cmd_store[seg * DEPTH + wr_idx[seg]] = {reg_byte, data_byte};
		wr_idx[seg] = next_idx;
		return 1'b1;
	endfunction

	// Advances the predicted state by one input beat and queues the beats it yields.
	task automatic predict_beats(input cldcq_pkg::in_item_t it);
		cldcq_pkg::out_item_t beat;
		logic [7:0]           frame [FRAME_BYTES];
		logic [15:0]          entry;
		int                   n;
		bit                   dropped;
		beat    = '0;
		dropped = 1'b0;
		if (it.operation == cldcq_pkg::OP_EXECUTE) begin
			// Highest segment first, a no-op for every empty ring.
			n = 0;
			for (int s = SEGS - 1; s >= 0; s--) begin
				if (rd_idx[s] == wr_idx[s]) begin
					frame[n]     = cldcq_pkg::NOOP_REG;
					frame[n + 1] = 8'd0;
				end else begin
					entry        = cmd_store[s * DEPTH + rd_idx[s]];
					frame[n]     = entry[15:8];
					frame[n + 1] = entry[7:0];
					rd_idx[s]    = 4'((rd_idx[s] + 1) % DEPTH);
				end
				n += 2;
			end
			for (int i = 0; i < FRAME_BYTES; i++) begin
				beat.kind       = cldcq_pkg::KIND_FRAME;
				beat.frame_byte = frame[i];
				beat.last       = (i == FRAME_BYTES - 1);
				beat.pending    = commands_waiting();
				beat.dropped    = 1'b0;
				expected_beats.push_back(beat);
			end
		end else begin
			if (it.operation == cldcq_pkg::OP_PUSH) begin
				dropped = !enqueue_command(it.segment, it.reg_addr, it.payload);
			end else if (it.operation == cldcq_pkg::OP_COLUMN) begin
				// Only a changed column in range produces a command.
				if (it.column < NCOLS && shadow_cols[it.column] != it.payload) begin
					if (enqueue_command(it.column / 8, 8'(it.column % 8 + 1), it.payload))
						shadow_cols[it.column] = it.payload;
					else
						dropped = 1'b1;
				end
			end
			beat.kind       = cldcq_pkg::KIND_STATUS;
			beat.frame_byte = 8'd0;
			beat.last       = 1'b1;
			beat.pending    = commands_waiting();
			beat.dropped    = dropped;
			expected_beats.push_back(beat);
		end
	endtask

	function automatic cldcq_pkg::in_item_t item_of(logic [1:0] op, logic [1:0] seg,
			logic [7:0] reg_byte, logic [7:0] data_byte, logic [4:0] col);
		cldcq_pkg::in_item_t it;
		it.operation = op;
		it.segment   = seg;
		it.reg_addr  = reg_byte;
		it.payload   = data_byte;
		it.column    = col;
		return it;
	endfunction

	// Offers one beat, with random idle cycles first, and returns at the edge that takes it.
	task automatic send_item(input cldcq_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_beats(it);
	endtask

	// Stops sending until every predicted beat has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Random output back-pressure.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compares each output beat with the oldest prediction; values are stable at the falling edge.
	always @(negedge clk) begin : check_beats
		cldcq_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: kind %0d byte %0d", out_item.kind, out_item.frame_byte);
				error_count++;
			end else begin
				want = expected_beats.pop_front();
				check_field("kind", want.kind, out_item.kind);
				check_field("frame_byte", want.frame_byte, out_item.frame_byte);
				check_field("last", want.last, out_item.last);
				check_field("pending", want.pending, out_item.pending);
				check_field("dropped", want.dropped, out_item.dropped);
			end
		end
	end

	// Counts cycles in which neither channel moves a beat.
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) @(negedge clk);
		$display("chained_led_driver_command_queue_top test failed");
		$finish;
	end

	// A frame with every ring empty is all no-ops.
	task automatic test_empty_frame();
		send_item(item_of(cldcq_pkg::OP_EXECUTE, 2'd0, 8'd0, 8'd0, 5'd0));
	endtask

	// Pushes, one with the extreme field values, then a frame that carries them.
	task automatic test_push_extremes();
		send_item(item_of(cldcq_pkg::OP_PUSH, 2'd3, 8'hFF, 8'hFF, 5'd31));
		send_item(item_of(cldcq_pkg::OP_PUSH, 2'd1, 8'hA5, 8'h5A, 5'd0));
		send_item(item_of(cldcq_pkg::OP_EXECUTE, 2'd3, 8'hFF, 8'hFF, 5'd31));
	endtask

	// The last column changes once, then a repeat of the same pixels queues nothing.
	task automatic test_column_writes();
		send_item(item_of(cldcq_pkg::OP_COLUMN, 2'd0, 8'd0, 8'hFF, 5'd31));
		send_item(item_of(cldcq_pkg::OP_COLUMN, 2'd3, 8'hFF, 8'hFF, 5'd31));
		send_item(item_of(cldcq_pkg::OP_EXECUTE, 2'd0, 8'd0, 8'd0, 5'd0));
	endtask

	// The unused operation only reports status.
	task automatic test_unused_operation();
		send_item(item_of(OP_UNUSED, 2'd3, 8'hFF, 8'hFF, 5'd31));
	endtask

	// Fills segment 0, then a push and a column write into the full ring are both dropped.
	task automatic test_queue_overflow();
		for (int i = 0; i < DEPTH - 1; i++)
			send_item(item_of(cldcq_pkg::OP_PUSH, 2'd0, 8'(i), 8'(8'hF0 ^ i), 5'(i)));
		send_item(item_of(cldcq_pkg::OP_PUSH, 2'd0, 8'hFF, 8'h00, 5'd0));
		send_item(item_of(cldcq_pkg::OP_COLUMN, 2'd2, 8'h00, 8'h81, 5'd3));
		wait_drained();
	endtask

	// One phase of random traffic, built from bursts of like operations.
	task automatic run_phase(input int target, input int idle_pct, input int stall_pct);
		cldcq_pkg::in_item_t it;
		int                  done;
		int                  roll;
		int                  len;
		int                  seg;
		send_idle_pct  = idle_pct;
		recv_stall_pct <= stall_pct;
		done = 0;
		while (done < target) begin
			roll = $urandom_range(99);
			if (roll < 30) begin
				// A run of pushes to one segment, long enough at times to overflow it.
				len = $urandom_range(18, 1);
				seg = $urandom_range(SEGS - 1);
				repeat (len) begin
					it           = cldcq_pkg::in_item_t'($urandom);
					it.operation = cldcq_pkg::OP_PUSH;
					it.segment   = 2'(seg);
					send_item(it);
					done++;
				end
			end else if (roll < 50) begin
				// Column writes, some repeating the pixels already shown.
				len = $urandom_range(8, 1);
				repeat (len) begin
					it           = cldcq_pkg::in_item_t'($urandom);
					it.operation = cldcq_pkg::OP_COLUMN;
					if ($urandom_range(3) == 0) it.payload = shadow_cols[it.column];
					send_item(it);
					done++;
				end
			end else if (roll < 85) begin
				len = $urandom_range(6, 1);
				repeat (len) begin
					it           = cldcq_pkg::in_item_t'($urandom);
					it.operation = cldcq_pkg::OP_EXECUTE;
					send_item(it);
					done++;
				end
			end else begin
				it           = cldcq_pkg::in_item_t'($urandom);
				it.operation = OP_UNUSED;
				send_item(it);
			end
		end
		wait_drained();
	endtask

	task automatic test_random_traffic();
		run_phase(70, 0, 0);
		run_phase(70, 80, 0);
		run_phase(70, 0, 80);
		run_phase(70, 18, 18);
	endtask

	initial begin
		for (int s = 0; s < SEGS; s++) begin
			wr_idx[s] = '0;
			rd_idx[s] = '0;
		end
		for (int c = 0; c < NCOLS; c++) shadow_cols[c] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_frame();
		test_push_extremes();
		test_column_writes();
		test_unused_operation();
		test_queue_overflow();
		test_random_traffic();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("chained_led_driver_command_queue_top test passed");
		else
			$display("chained_led_driver_command_queue_top test failed");
		$finish;
	end

endmodule
